### rtl/led_fb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_fb_pkg
// Shared operation codes, constants and controller/datapath interface
// structs for the blinking LED matrix framebuffer.
// ---------------------------------------------------------------------------
package led_fb_pkg;

  localparam int MATRICES_DEFAULT = 4;
  localparam int ROWS             = 8;
  localparam logic [7:0] BLANK_ROW = 8'h00;

  typedef enum logic [2:0] {
    OP_SET_ROW     = 3'd0,
    OP_PIXEL_ON    = 3'd1,
    OP_PIXEL_OFF   = 3'd2,
    OP_BLINK_ROW   = 3'd3,
    OP_BLINK_PIXEL = 3'd4,
    OP_CLEAR       = 3'd5,
    OP_REFRESH     = 3'd6
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;     // latch the input item and read its row
    logic write_back;    // write the modified row to both stores
    logic clear_matrix;  // invalidate all rows of the addressed matrix
    logic cnt_clear;     // restart the refresh walk
    logic fetch;         // read the row under the refresh counters
    logic load_out;      // move the fetched row into the output register
    logic cnt_step;      // advance the refresh counters
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_refresh;
    logic is_update;
    logic is_clear;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage : led_fb_pkg
`default_nettype wire

### rtl/led_matrix_blink_framebuffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_matrix_blink_framebuffer
// Two-phase row framebuffer for a chain of 8x8 LED matrices.
// ---------------------------------------------------------------------------
// Each matrix has a phase-A and a phase-B row store held in a memory with
// one read port. Row and pixel updates are a read followed by a write-back;
// clear, out-of-range and unused items finish in the idle state. Refresh
// streams 16 * MATRICES beats (all phase-A rows matrix by matrix, then all
// phase-B rows), each beat passing through a fetch state and then a hand-off
// state, since beats share the one memory read port; the hand-off waits while
// the output stalls. Both stores read as blank after reset with no clearing
// pass. The last refresh beat may still wait in the output register while
// the next item is accepted.
// ---------------------------------------------------------------------------
module led_matrix_blink_framebuffer
  import led_fb_pkg::*;
#(
  parameter int MATRICES = MATRICES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] operation,
  input  wire logic [1:0] matrix,
  input  wire logic [3:0] row,
  input  wire logic [3:0] column,
  input  wire logic [7:0] pattern,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      matrix_select,
  output logic [3:0]      digit_address,
  output logic [7:0]      row_data,
  output logic            phase,
  output logic            last
);

  cmd_t    cmd;
  status_t status;

  led_fb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  led_fb_datapath #(
    .MATRICES (MATRICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .matrix        (matrix),
    .row           (row),
    .column        (column),
    .pattern       (pattern),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .matrix_select (matrix_select),
    .digit_address (digit_address),
    .row_data      (row_data),
    .phase         (phase),
    .last          (last)
  );

endmodule : led_matrix_blink_framebuffer
`default_nettype wire

### rtl/led_fb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_fb_datapath
// Row stores for both blink phases, item decode, read-modify-write logic,
// refresh counters and the output register.
// ---------------------------------------------------------------------------
module led_fb_datapath
  import led_fb_pkg::*;
#(
  parameter int MATRICES = MATRICES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output status_t         status,
  input  wire logic [2:0] operation,
  input  wire logic [1:0] matrix,
  input  wire logic [3:0] row,
  input  wire logic [3:0] column,
  input  wire logic [7:0] pattern,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      matrix_select,
  output logic [3:0]      digit_address,
  output logic [7:0]      row_data,
  output logic            phase,
  output logic            last
);

  localparam int MAT_W = (MATRICES > 1) ? $clog2(MATRICES) : 1;
  localparam int AW    = MAT_W + 3;
  localparam int DEPTH = ROWS * MATRICES;

  // Row stores; an entry whose valid bit is clear reads as a blank row.
  logic [7:0]       a_mem [DEPTH];
  logic [7:0]       b_mem [DEPTH];
  logic [DEPTH-1:0] row_valid;

  logic [7:0]       rd_a;
  logic [7:0]       rd_b;
  logic             rd_v;
  logic [7:0]       cur_a;
  logic [7:0]       cur_b;

  // Latched item.
  logic [2:0]       op_q;
  logic [AW-1:0]    idx_q;
  logic [7:0]       pat_q;
  logic [7:0]       mask_q;

  // Refresh walk counters.
  logic [2:0]       row_cnt;
  logic [MAT_W-1:0] mat_cnt;
  logic             ph_cnt;

  logic [4:0]       mat_ext;
  logic [4:0]       cnt_ext;
  logic             matrix_ok;
  logic             row_ok;
  logic             col_ok;
  logic [2:0]       row_idx;
  logic [2:0]       col_idx;
  logic [AW-1:0]    item_idx;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic [7:0]       new_a;
  logic [7:0]       new_b;
  logic             row_end;
  logic             mat_end;

  // Item decode.
  assign mat_ext   = 5'(matrix);
  assign matrix_ok = (mat_ext < 5'(MATRICES));
  assign row_ok    = (row >= 4'd1) && (row <= 4'(ROWS));
  assign col_ok    = (column >= 4'd1) && (column <= 4'(ROWS));
  assign row_idx   = 3'(row - 4'd1);
  assign col_idx   = 3'(column - 4'd1);
  assign item_idx  = {mat_ext[MAT_W-1:0], row_idx};

  assign row_end = (row_cnt == 3'(ROWS - 1));
  assign mat_end = (mat_cnt == MAT_W'(MATRICES - 1));

  always_comb begin
    status.is_refresh = (operation == OP_REFRESH);
    status.is_clear   = (operation == OP_CLEAR) && matrix_ok;
    status.cnt_last   = ph_cnt && mat_end && row_end;
    status.out_free   = !out_valid || !out_stall;
    status.is_update  = 1'b0;
    unique case (operation)
      OP_SET_ROW, OP_BLINK_ROW: status.is_update = matrix_ok && row_ok;
      OP_PIXEL_ON, OP_PIXEL_OFF, OP_BLINK_PIXEL:
        status.is_update = matrix_ok && row_ok && col_ok;
      default: status.is_update = 1'b0;
    endcase
  end

  // Memory read port, shared by updates and the refresh walk.
  assign rd_en   = cmd.load_item || cmd.fetch;
  assign rd_addr = cmd.load_item ? item_idx : {mat_cnt, row_cnt};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= a_mem[rd_addr];
      rd_b <= b_mem[rd_addr];
      rd_v <= row_valid[rd_addr];
    end
    if (cmd.write_back) begin
      a_mem[idx_q] <= new_a;
      b_mem[idx_q] <= new_b;
    end
  end

  assign cur_a = rd_v ? rd_a : BLANK_ROW;
  assign cur_b = rd_v ? rd_b : BLANK_ROW;

  always_comb begin
    new_a = cur_a;
    new_b = cur_b;
    unique case (op_q)
      OP_SET_ROW: begin
        new_a = pat_q;
        new_b = pat_q;
      end
      OP_BLINK_ROW: begin
        new_a = pat_q;
        new_b = BLANK_ROW;
      end
      OP_PIXEL_ON: begin
        new_a = cur_a | mask_q;
        new_b = cur_b | mask_q;
      end
      OP_PIXEL_OFF: begin
        new_a = cur_a & ~mask_q;
        new_b = cur_b & ~mask_q;
      end
      OP_BLINK_PIXEL: begin
        new_a = cur_a | mask_q;
        new_b = cur_b & ~mask_q;
      end
      default: begin
        new_a = cur_a;
        new_b = cur_b;
      end
    endcase
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= operation;
      idx_q  <= item_idx;
      pat_q  <= pattern;
      mask_q <= 8'b1 << col_idx;
    end
  end

  // Valid bits give the stores their blank state after reset and on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else begin
      if (cmd.write_back) begin
        row_valid[idx_q] <= 1'b1;
      end
      if (cmd.clear_matrix) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i[AW-1:3] == mat_ext[MAT_W-1:0]) begin
            row_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  // Refresh counters: rows within a matrix, then matrices, then phase.
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clear) begin
      row_cnt <= '0;
      mat_cnt <= '0;
      ph_cnt  <= 1'b0;
    end else if (cmd.cnt_step) begin
      row_cnt <= row_cnt + 3'd1;
      if (row_end) begin
        if (mat_end) begin
          mat_cnt <= '0;
          ph_cnt  <= !ph_cnt;
        end else begin
          mat_cnt <= mat_cnt + MAT_W'(1);
        end
      end
    end
  end

  assign cnt_ext = 5'(mat_cnt);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      matrix_select <= cnt_ext[1:0];
      digit_address <= {1'b0, row_cnt} + 4'd1;
      row_data      <= ph_cnt ? cur_b : cur_a;
      phase         <= ph_cnt;
      last          <= status.cnt_last;
    end
  end

endmodule : led_fb_datapath
`default_nettype wire

### rtl/led_fb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_fb_ctrl
// Sequencer for updates (read, then write back) and the refresh walk
// (fetch a row, then hand it to the output register).
// ---------------------------------------------------------------------------
module led_fb_ctrl
  import led_fb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.is_refresh) begin
            cmd.cnt_clear = 1'b1;
            state_next    = ST_FETCH;
          end else if (status.is_update) begin
            cmd.load_item = 1'b1;
            state_next    = ST_MODIFY;
          end else if (status.is_clear) begin
            cmd.clear_matrix = 1'b1;
          end
        end
      end
      ST_MODIFY: begin
        cmd.write_back = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the fetched row until the output register can take it.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.cnt_step = 1'b1;
          state_next   = status.cnt_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : led_fb_ctrl
`default_nettype wire

### rtl/led_fb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// led_fb_checker
// Port-level checks for the blinking LED matrix framebuffer.
// ---------------------------------------------------------------------------
module led_fb_checker
  import led_fb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [2:0] operation,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] matrix_select,
  input wire logic [3:0] digit_address,
  input wire logic [7:0] row_data,
  input wire logic       phase,
  input wire logic       last
);

  // A stalled beat stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_data) && $stable(digit_address)
      && $stable(matrix_select) && $stable(phase) && $stable(last))
    else $error("stalled output beat changed");

  // The final beat of a refresh is the last row of phase B.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> phase && (digit_address == 4'd8))
    else $error("last beat is not phase B row 8");

  // A refresh keeps the input side busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_REFRESH) |=> in_stall)
    else $error("input taken right after a refresh started");

  // While a non-final refresh beat is delivered, the walk is still running.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |-> in_stall)
    else $error("input side open in the middle of a refresh");

endmodule : led_fb_checker

bind led_matrix_blink_framebuffer led_fb_checker u_led_fb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .operation     (operation),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .matrix_select (matrix_select),
  .digit_address (digit_address),
  .row_data      (row_data),
  .phase         (phase),
  .last          (last)
);
`default_nettype wire

### dv/led_matrix_blink_framebuffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_blink_framebuffer_tb
// Self-checking bench for the two-phase LED matrix framebuffer. A directed
// table covers field extremes, every operation and the ignored cases. Random
// update and refresh traffic follows under three idling mixes and one long
// output hold-off. Every refresh beat is checked against a local model of
// both row stores, or against its fixed row for a typed refresh.
// ----------------------------------------------------------------------------
module led_matrix_blink_framebuffer_tb;
  import led_fb_pkg::*;

  localparam int N_MAT = MATRICES_DEFAULT;
  localparam int N_ROWS_ALL = N_MAT * ROWS;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int N_DIRECTED = 23;
  localparam int RANDOM_PER_PART = 69;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;
  localparam int DRAIN_LIMIT = 200000;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] mat;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] pat;
    logic       typed;      // refresh whose every beat carries typed_row
    logic [7:0] typed_row;
  } stim_t;

  typedef struct packed {
    logic [1:0] sel;
    logic [3:0] digit;
    logic [7:0] data;
    logic       ph;
    logic       lst;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] operation;
  logic [1:0] matrix;
  logic [3:0] row;
  logic [3:0] column;
  logic [7:0] pattern;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] matrix_select;
  logic [3:0] digit_address;
  logic [7:0] row_data;
  logic       phase;
  logic       last;

  logic [7:0] frame_on [N_ROWS_ALL];
  logic [7:0] frame_off [N_ROWS_ALL];
  beat_t      pending_beats [$];
  stim_t      directed_tbl [N_DIRECTED];

  int idle_mode = 0;
  int errors = 0;
  int items_taken = 0;
  int refreshes = 0;
  int ignored_items = 0;
  int beats_checked = 0;

  led_matrix_blink_framebuffer #(.MATRICES(N_MAT)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .matrix       (matrix),
    .row          (row),
    .column       (column),
    .pattern      (pattern),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matrix_select(matrix_select),
    .digit_address(digit_address),
    .row_data     (row_data),
    .phase        (phase),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("led_matrix_blink_framebuffer_tb: errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Updates both row stores for one accepted item and queues the beats of a
  // refresh.
  task automatic apply_to_frames(input stim_t s);
    int base;
    int idx;
    logic [7:0] bit_mask;
    logic row_ok;
    logic col_ok;
    beat_t b;
    base = int'(s.mat) * ROWS;
    row_ok = (s.row >= 1) && (s.row <= ROWS);
    col_ok = (s.col >= 1) && (s.col <= ROWS);
    idx = base + int'(s.row) - 1;
    bit_mask = 8'h01 << (s.col - 4'd1);
    case (s.op)
      OP_REFRESH: begin
        refreshes++;
        for (int ph = 0; ph < 2; ph++) begin
          for (int m = 0; m < N_MAT; m++) begin
            for (int r = 0; r < ROWS; r++) begin
              b.sel = m[1:0];
              b.digit = 4'(r + 1);
              b.data = (ph == 0) ? frame_on[m * ROWS + r] : frame_off[m * ROWS + r];
              if (s.typed) begin
                b.data = s.typed_row;
              end
              b.ph = ph[0];
              b.lst = (ph == 1) && (m == N_MAT - 1) && (r == ROWS - 1);
              pending_beats.push_back(b);
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < ROWS; r++) begin
          frame_on[base + r] = BLANK_ROW;
          frame_off[base + r] = BLANK_ROW;
        end
      end
      OP_SET_ROW, OP_BLINK_ROW: begin
        if (!row_ok) begin
          ignored_items++;
        end else begin
          frame_on[idx] = s.pat;
          frame_off[idx] = (s.op == OP_SET_ROW) ? s.pat : BLANK_ROW;
        end
      end
      OP_PIXEL_ON, OP_PIXEL_OFF, OP_BLINK_PIXEL: begin
        if (!row_ok || !col_ok) begin
          ignored_items++;
        end else if (s.op == OP_PIXEL_ON) begin
          frame_on[idx] = frame_on[idx] | bit_mask;
          frame_off[idx] = frame_off[idx] | bit_mask;
        end else if (s.op == OP_PIXEL_OFF) begin
          frame_on[idx] = frame_on[idx] & ~bit_mask;
          frame_off[idx] = frame_off[idx] & ~bit_mask;
        end else begin
          frame_on[idx] = frame_on[idx] | bit_mask;
          frame_off[idx] = frame_off[idx] & ~bit_mask;
        end
      end
      default: begin
        ignored_items++;
      end
    endcase
  endtask

  // Mostly in-range coordinates; about one in ten lands outside 1..8.
  function automatic logic [3:0] pick_coord();
    int v;
    if ($urandom_range(0, 9) == 0) begin
      v = $urandom_range(8, 15);
      return (v == 8) ? 4'd0 : 4'(v);
    end
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s.op = OP_REFRESH;
    end else if (pick < 11) begin
      s.op = OP_UNUSED;
    end else begin
      s.op = 3'($urandom_range(0, 5));
    end
    s.mat = 2'($urandom_range(0, N_MAT - 1));
    s.row = pick_coord();
    s.col = pick_coord();
    s.pat = 8'($urandom_range(0, 255));
    s.typed = 1'b0;
    s.typed_row = 8'h00;
    return s;
  endfunction

  function automatic int send_idle_pct();
    return (idle_mode == 0) ? 28 : (idle_mode == 1) ? 65 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (idle_mode == 0) ? 65 : (idle_mode == 1) ? 28 : 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_item(input stim_t s);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= s.op;
    matrix <= s.mat;
    row <= s.row;
    column <= s.col;
    pattern <= s.pat;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    apply_to_frames(s);
    items_taken++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{matrix_select, digit_address, row_data, phase, last};
      beats_checked++;
      if (pending_beats.size() == 0) begin
        flag_error($sformatf("unexpected beat sel=%0d digit=%0d data=%02h ph=%0d last=%0d",
                             got.sel, got.digit, got.data, got.ph, got.lst));
      end else begin
        want = pending_beats.pop_front();
        if (got.sel !== want.sel || got.digit !== want.digit || got.data !== want.data ||
            got.ph !== want.ph || got.lst !== want.lst) begin
          flag_error($sformatf({"beat mismatch: expected sel=%0d digit=%0d data=%02h ph=%0d ",
                                "last=%0d, got sel=%0d digit=%0d data=%02h ph=%0d last=%0d"},
                               want.sel, want.digit, want.data, want.ph, want.lst,
                               got.sel, got.digit, got.data, got.ph, got.lst));
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off when the last mix
  // starts so that the block backs up into its input.
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_mode == 2 && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
      end
    end
  end

  initial begin
    stim_t s;
    int drain;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    matrix = '0;
    row = '0;
    column = '0;
    pattern = '0;
    for (int i = 0; i < N_ROWS_ALL; i++) begin
      frame_on[i] = BLANK_ROW;
      frame_off[i] = BLANK_ROW;
    end
    // op, matrix, row, column, pattern, typed, typed_row
    directed_tbl = '{
      '{OP_REFRESH,     2'd0, 4'd1,  4'd1,  8'h00, 1'b1, 8'h00},
      '{OP_SET_ROW,     2'd0, 4'd1,  4'd1,  8'hFF, 1'b0, 8'h00},
      '{OP_SET_ROW,     2'd3, 4'd8,  4'd8,  8'hA5, 1'b0, 8'h00},
      '{OP_PIXEL_ON,    2'd1, 4'd2,  4'd1,  8'h00, 1'b0, 8'h00},
      '{OP_PIXEL_ON,    2'd1, 4'd2,  4'd8,  8'h00, 1'b0, 8'h00},
      '{OP_PIXEL_OFF,   2'd0, 4'd1,  4'd8,  8'h00, 1'b0, 8'h00},
      '{OP_BLINK_ROW,   2'd2, 4'd5,  4'd3,  8'h3C, 1'b0, 8'h00},
      '{OP_BLINK_PIXEL, 2'd2, 4'd5,  4'd1,  8'h00, 1'b0, 8'h00},
      '{OP_BLINK_PIXEL, 2'd1, 4'd8,  4'd8,  8'hFF, 1'b0, 8'h00},
      '{OP_SET_ROW,     2'd1, 4'd0,  4'd1,  8'h77, 1'b0, 8'h00},
      '{OP_SET_ROW,     2'd1, 4'd9,  4'd1,  8'h77, 1'b0, 8'h00},
      '{OP_PIXEL_ON,    2'd0, 4'd3,  4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_PIXEL_ON,    2'd0, 4'd3,  4'd15, 8'h00, 1'b0, 8'h00},
      '{OP_BLINK_ROW,   2'd0, 4'd15, 4'd1,  8'hFF, 1'b0, 8'h00},
      '{OP_UNUSED,      2'd0, 4'd1,  4'd1,  8'hFF, 1'b0, 8'h00},
      '{OP_REFRESH,     2'd3, 4'd15, 4'd15, 8'hFF, 1'b0, 8'h00},
      '{OP_PIXEL_OFF,   2'd3, 4'd8,  4'd9,  8'h00, 1'b0, 8'h00},
      '{OP_CLEAR,       2'd0, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_REFRESH,     2'd0, 4'd0,  4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_CLEAR,       2'd1, 4'd12, 4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_CLEAR,       2'd2, 4'd1,  4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_CLEAR,       2'd3, 4'd8,  4'd0,  8'h00, 1'b0, 8'h00},
      '{OP_REFRESH,     2'd1, 4'd8,  4'd8,  8'h00, 1'b1, 8'h00}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_tbl[i]) begin
      offer_item(directed_tbl[i]);
    end

    for (int part = 0; part < 3; part++) begin
      idle_mode = part;
      for (int k = 0; k < RANDOM_PER_PART; k++) begin
        s = random_item();
        // A refresh right at the hold-off makes the output back up.
        if (part == 2 && k == 0) begin
          s.op = OP_REFRESH;
        end
        offer_item(s);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_beats.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      flag_error($sformatf("%0d expected beats never arrived", pending_beats.size()));
    end

    $display("Covered %0d items (%0d refreshes, %0d ignored) under three idling mixes.",
             items_taken, refreshes, ignored_items);
    $display("Checked %0d refresh beats; %0d errors found.", beats_checked, errors);
    if (errors == 0) begin
      $display("led_matrix_blink_framebuffer_tb: clean");
    end else begin
      $display("led_matrix_blink_framebuffer_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/led_fb_pkg.sv
rtl/led_fb_datapath.sv
rtl/led_fb_ctrl.sv
rtl/led_matrix_blink_framebuffer.sv
rtl/led_fb_checker.sv
dv/led_matrix_blink_framebuffer_tb.sv
